/* rtl/core/clss_pkg.sv */
// ----------------------------------------------------------------------------
// clss_pkg
// Types, constants and elaboration-time helpers shared by the
// conditional-likelihood site step.
// ----------------------------------------------------------------------------
package clss_pkg;

  localparam int NUM_LANES = 8;   // four parent bases times two children
  localparam int NUM_BASES = 4;
  localparam int EXP_BITS  = 20;
  localparam int LOG_BITS  = 20;
  // register stages inside one lane, from queue head to log2 result
  localparam int LANE_LAT  = 2 * EXP_BITS + 6;

  localparam logic signed [15:0] ZERO_CODE = 16'sh8000;
  localparam logic signed [15:0] LOG_MAX   = 16'sh7fff;
  localparam logic [16:0]        LOG2E_Q16 = 17'd94548;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MAT_A_ROW0 = 3'd0,
    REG_MAT_A_ROW1 = 3'd1,
    REG_MAT_A_ROW2 = 3'd2,
    REG_MAT_A_ROW3 = 3'd3,
    REG_MAT_B_ROW0 = 3'd4,
    REG_MAT_B_ROW1 = 3'd5,
    REG_MAT_B_ROW2 = 3'd6,
    REG_MAT_B_ROW3 = 3'd7
  } clss_reg_t;

  // classified work for one (parent base, child) lane
  typedef struct packed {
    logic [3:0]             act;
    logic signed [15:0]     mx;
    logic [3:0][15:0]       d;
  } clss_lane_in_t;

  // one queued site
  typedef struct packed {
    clss_lane_in_t [NUM_LANES-1:0] lane;
    logic                          last;
  } clss_item_t;

  // integer square root, bit by bit (elaboration only)
  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = x;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-b) in Q32, by repeated square roots of 2^-1
  function automatic logic [31:0] root_q32(int b);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 1; i <= b; i++) begin
      r = isqrt64(r << 32);
    end
    return r[31:0];
  endfunction

endpackage

/* rtl/core/clss_if.sv */
// ----------------------------------------------------------------------------
// clss_if
// Channel interfaces: site input, parent result and register write.
// ----------------------------------------------------------------------------
interface clss_site_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_log0;
  logic signed [15:0] a_log1;
  logic signed [15:0] a_log2;
  logic signed [15:0] a_log3;
  logic signed [15:0] b_log0;
  logic signed [15:0] b_log1;
  logic signed [15:0] b_log2;
  logic signed [15:0] b_log3;
  logic               last_site;
  modport source (output valid, a_log0, a_log1, a_log2, a_log3, b_log0, b_log1,
                  b_log2, b_log3, last_site, input ready);
  modport sink (input valid, a_log0, a_log1, a_log2, a_log3, b_log0, b_log1,
                b_log2, b_log3, last_site, output ready);
endinterface

interface clss_parent_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] c_log0;
  logic signed [15:0] c_log1;
  logic signed [15:0] c_log2;
  logic signed [15:0] c_log3;
  logic               underflow;
  logic               last_out;
  modport source (output valid, c_log0, c_log1, c_log2, c_log3, underflow, last_out,
                  input ready);
  modport sink (input valid, c_log0, c_log1, c_log2, c_log3, underflow, last_out,
                output ready);
endinterface

interface clss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/clss_front.sv */
// ----------------------------------------------------------------------------
// clss_front
// Accepts a site, finds the active set and maximum log of every lane and
// registers the classified item for the queue.
// ----------------------------------------------------------------------------
module clss_front (
  input  logic                          clk,
  input  logic                          rst,
  clss_site_if.sink                     site,
  input  logic [7:0][63:0]              mat,
  output clss_pkg::clss_item_t          item,
  output logic                          item_valid,
  input  logic                          item_ready
);
  import clss_pkg::*;

  logic signed [15:0] la [4];
  logic signed [15:0] lb [4];
  clss_lane_in_t      lane_c [NUM_LANES];
  clss_item_t         cls;
  logic               site_xfer;

  assign la[0] = site.a_log0;
  assign la[1] = site.a_log1;
  assign la[2] = site.a_log2;
  assign la[3] = site.a_log3;
  assign lb[0] = site.b_log0;
  assign lb[1] = site.b_log1;
  assign lb[2] = site.b_log2;
  assign lb[3] = site.b_log3;

  assign site.ready = !item_valid || item_ready;
  assign site_xfer  = site.valid && site.ready;

  // classify each lane: active inputs, their maximum and distances to it
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_cls
    always_comb begin
      logic signed [15:0] lg [4];
      logic [3:0]         act;
      logic               any;
      logic signed [15:0] mx;
      logic signed [16:0] dd;
      for (int x = 0; x < 4; x++) begin
        lg[x]  = (g < NUM_BASES) ? la[x] : lb[x];
        act[x] = (mat[g][16*x +: 16] != 16'd0) && (lg[x] != ZERO_CODE);
      end
      any = 1'b0;
      mx  = ZERO_CODE;
      for (int x = 0; x < 4; x++) begin
        if (act[x] && (!any || lg[x] > mx)) begin
          mx  = lg[x];
          any = 1'b1;
        end
      end
      lane_c[g].act = act;
      lane_c[g].mx  = mx;
      for (int x = 0; x < 4; x++) begin
        dd = {mx[15], mx} - {lg[x][15], lg[x]};
        lane_c[g].d[x] = act[x] ? dd[15:0] : 16'd0;
      end
    end
  end

  // pack the lanes with the sideband
  always_comb begin
    for (int g = 0; g < NUM_LANES; g++) begin
      cls.lane[g] = lane_c[g];
    end
    cls.last = site.last_site;
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (site.ready) begin
      item_valid <= site_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (site_xfer) begin
      item <= cls;
    end
  end

endmodule

/* rtl/core/clss_queue.sv */
// ----------------------------------------------------------------------------
// clss_queue
// Short FIFO between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module clss_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  clss_pkg::clss_item_t push_item,
  input  logic                 push_valid,
  output logic                 push_ready,
  output clss_pkg::clss_item_t head,
  output logic                 head_valid,
  input  logic                 pop
);
  import clss_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  clss_item_t      mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            push;

  assign push_ready = (count != CW'(DEPTH));
  assign push       = push_valid && push_ready;
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

/* rtl/core/clss_lane.sv */
// ----------------------------------------------------------------------------
// clss_lane
// One child sum for one parent base: exp2 by a chain of root multiplies,
// weighted sum, then log2 by repeated squaring. LANE_LAT register stages, all held while en is low.
// ----------------------------------------------------------------------------
module clss_lane (
  input  logic                    clk,
  input  logic                    en,
  input  clss_pkg::clss_lane_in_t li,
  input  logic [63:0]             row,
  output logic signed [26:0]      l2
);
  import clss_pkg::*;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // exponent split: integer shift, fraction bits, zero flag
  logic [3:0][32:0]  u;
  logic [3:0]        z0;
  logic [3:0][4:0]   n0;
  logic [3:0][19:0]  f0;

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      u[x] = {17'd0, li.d[x]} * {16'd0, LOG2E_Q16};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int x = 0; x < 4; x++) begin
        z0[x] <= !li.act[x] || (u[x][32:31] != 2'b00);
        n0[x] <= u[x][30:26];
        f0[x] <= u[x][25:6];
      end
    end
  end

  // exp2 chain, one fraction bit per stage
  logic [3:0][32:0] m_s [1:EXP_BITS];
  logic [3:0][19:0] f_s [1:EXP_BITS];
  logic [3:0][4:0]  n_s [1:EXP_BITS];
  logic [3:0]       z_s [1:EXP_BITS];

  for (genvar b = 1; b <= EXP_BITS; b++) begin : g_exp
    localparam logic [31:0] RB = root_q32(b);
    logic [3:0][32:0] src;
    logic [3:0][19:0] fsrc;
    logic [3:0][4:0]  nsrc;
    logic [3:0]       zsrc;
    logic [3:0][64:0] prod;

    if (b == 1) begin : g_first
      assign src  = {4{ONE_Q32}};
      assign fsrc = f0;
      assign nsrc = n0;
      assign zsrc = z0;
    end else begin : g_next
      assign src  = m_s[b-1];
      assign fsrc = f_s[b-1];
      assign nsrc = n_s[b-1];
      assign zsrc = z_s[b-1];
    end

    always_comb begin
      for (int x = 0; x < 4; x++) begin
        prod[x] = {32'd0, src[x]} * {33'd0, RB};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int x = 0; x < 4; x++) begin
          m_s[b][x] <= fsrc[x][EXP_BITS-b] ? prod[x][64:32] : src[x];
        end
        f_s[b] <= fsrc;
        n_s[b] <= nsrc;
        z_s[b] <= zsrc;
      end
    end
  end

  // integer part of the exponent
  logic [3:0][32:0] e;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int x = 0; x < 4; x++) begin
        e[x] <= z_s[EXP_BITS][x] ? 33'd0 : (m_s[EXP_BITS][x] >> n_s[EXP_BITS][x]);
      end
    end
  end

  // weight by transition entry
  logic [3:0][48:0] t;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int x = 0; x < 4; x++) begin
        t[x] <= {33'd0, row[16*x +: 16]} * {16'd0, e[x]};
      end
    end
  end

  // Q47 sum
  logic [50:0] s;
  always_ff @(posedge clk) begin
    if (en) begin
      s <= {2'b00, t[0]} + {2'b00, t[1]} + {2'b00, t[2]} + {2'b00, t[3]};
    end
  end

  // leading one: the maximum term is exactly 2^32 times a nonzero entry
  logic [5:0]  pe_p;
  logic [50:0] pe_s;
  always_ff @(posedge clk) begin
    logic [5:0] p;
    if (en) begin
      p = 6'd32;
      for (int i = 33; i <= 50; i++) begin
        if (s[i]) begin
          p = 6'(i);
        end
      end
      pe_s <= s;
      pe_p <= p;
    end
  end

  // normalize to [2^30, 2^31)
  logic [30:0] nz;
  logic [5:0]  np;
  logic [5:0]  sh;
  logic [50:0] shifted;
  assign sh      = pe_p - 6'd30;
  assign shifted = pe_s >> sh;
  always_ff @(posedge clk) begin
    if (en) begin
      nz <= shifted[30:0];
      np <= pe_p;
    end
  end

  // log2 fraction, one bit per squaring
  logic [30:0] q_z [1:LOG_BITS];
  logic [5:0]  q_p [1:LOG_BITS];
  logic [19:0] q_f [1:LOG_BITS];

  for (genvar i = 1; i <= LOG_BITS; i++) begin : g_log
    logic [30:0] zin;
    logic [5:0]  pin;
    logic [19:0] fin;
    logic [61:0] sq;
    logic [31:0] sqt;

    if (i == 1) begin : g_first
      assign zin = nz;
      assign pin = np;
      assign fin = 20'd0;
    end else begin : g_next
      assign zin = q_z[i-1];
      assign pin = q_p[i-1];
      assign fin = q_f[i-1];
    end

    assign sq  = {31'd0, zin} * {31'd0, zin};
    assign sqt = sq[61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        q_z[i] <= sqt[31] ? sqt[31:1] : sqt[30:0];
        q_f[i] <= {fin[18:0], sqt[31]};
        q_p[i] <= pin;
      end
    end
  end

  // (p - 47) in the integer part, fraction below
  logic signed [6:0] pint;
  assign pint = $signed({1'b0, q_p[LOG_BITS]}) - 7'sd47;
  assign l2   = {pint, q_f[LOG_BITS]};

endmodule

/* rtl/core/clss_back.sv */
// ----------------------------------------------------------------------------
// clss_back
// Arithmetic pipeline: eight lanes, then the ln2 scale, rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module clss_back (
  input  logic                 clk,
  input  logic                 rst,
  input  clss_pkg::clss_item_t head,
  input  logic                 head_valid,
  output logic                 pop,
  input  logic [7:0][63:0]     mat,
  clss_parent_if.source        parent
);
  import clss_pkg::*;

  typedef struct packed {
    logic [NUM_LANES-1:0]            any;
    logic [NUM_LANES-1:0][15:0]      mx;
    logic                            last;
  } side_t;

  logic                         adv;
  logic [LANE_LAT-1:0]          sv;
  side_t                        sd [LANE_LAT];
  side_t                        side_in;
  logic signed [26:0]           l2 [NUM_LANES];

  // whole pipeline moves unless the output register is held
  assign adv = !parent.valid || parent.ready;
  assign pop = adv && head_valid;

  always_comb begin
    for (int g = 0; g < NUM_LANES; g++) begin
      side_in.any[g] = |head.lane[g].act;
      side_in.mx[g]  = head.lane[g].mx;
    end
    side_in.last = head.last;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    clss_lane u_lane (
      .clk (clk),
      .en  (adv),
      .li  (head.lane[g]),
      .row (mat[g]),
      .l2  (l2[g])
    );
  end

  // sideband delay matching the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (adv) begin
      sv <= {sv[LANE_LAT-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= side_in;
      for (int i = 1; i < LANE_LAT; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // scale the log2 sum by ln2
  logic                       f1v;
  logic [3:0]                 f1ok;
  logic [3:0][58:0]           f1v_prod;
  logic [3:0][16:0]           f1m;
  logic                       f1last;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1v <= 1'b0;
    end else if (adv) begin
      f1v <= sv[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [27:0] ls;
    logic signed [16:0] ms;
    if (adv) begin
      for (int k = 0; k < NUM_BASES; k++) begin
        ls = 28'(l2[k]) + 28'(l2[k+NUM_BASES]);
        ms = 17'($signed(sd[LANE_LAT-1].mx[k])) +
             17'($signed(sd[LANE_LAT-1].mx[k+NUM_BASES]));
        f1v_prod[k] <= 59'(59'(ls) * 59'($signed({1'b0, LN2_Q30})));
        f1m[k]      <= ms;
        f1ok[k]     <= sd[LANE_LAT-1].any[k] && sd[LANE_LAT-1].any[k+NUM_BASES];
      end
      f1last <= sd[LANE_LAT-1].last;
    end
  end

  // round half up, add maxima, saturate
  logic [3:0][15:0] res;
  logic             uf;
  always_comb begin
    logic signed [58:0] h;
    logic signed [18:0] r;
    logic signed [19:0] tot;
    uf = 1'b0;
    for (int k = 0; k < NUM_BASES; k++) begin
      h   = $signed(f1v_prod[k]) + 59'sh80_0000_0000;
      r   = 19'(h >>> 40);
      tot = 20'($signed(f1m[k])) + 20'(r);
      if (!f1ok[k]) begin
        res[k] = ZERO_CODE;
      end else if (tot > 20'sd32767) begin
        res[k] = LOG_MAX;
      end else if (tot < -20'sd32767) begin
        res[k] = ZERO_CODE;
        uf     = 1'b1;
      end else begin
        res[k] = tot[15:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      parent.valid <= 1'b0;
    end else if (adv) begin
      parent.valid <= f1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      parent.c_log0    <= res[0];
      parent.c_log1    <= res[1];
      parent.c_log2    <= res[2];
      parent.c_log3    <= res[3];
      parent.underflow <= uf;
      parent.last_out  <= f1last;
    end
  end

endmodule

/* rtl/core/conditional_likelihood_site_step.sv */
// ----------------------------------------------------------------------------
// conditional_likelihood_site_step
// Parent conditional likelihoods of one alignment site from its two children.
// ----------------------------------------------------------------------------
// Takes one site per clock while the output is not held and returns one
// result per site, in order. A site is classified and registered in the
// front stage, waits in a short FIFO, then runs through eight parallel lanes
// (four parent bases times two children) of 20 root-multiply stages for exp2
// and 20 squaring stages for log2, plus the ln2 scale and the output
// register. The rate is one site per cycle, set by the fully pipelined
// lanes; a held output stalls the pipeline, and the FIFO then fills before
// the input ready drops. Register writes take effect at once and must be
// made while no site is in flight; cfg.ready is always high.
module conditional_likelihood_site_step #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  clss_site_if.sink     site,
  clss_parent_if.source parent,
  clss_cfg_if.sink      cfg
);
  import clss_pkg::*;

  logic [7:0][63:0] mat;
  clss_item_t       f_item;
  logic             f_valid;
  logic             f_ready;
  clss_item_t       q_head;
  logic             q_valid;
  logic             q_pop;

  // transition matrix rows
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= '0;
    end else if (cfg.valid) begin
      mat[cfg.index] <= cfg.data;
    end
  end

  clss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .site       (site),
    .mat        (mat),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  clss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop)
  );

  clss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .mat        (mat),
    .parent     (parent)
  );

endmodule

/* rtl/core/clss_check.sv */
// ----------------------------------------------------------------------------
// clss_check
// Port-level checks of the site step, bound to the top level.
// ----------------------------------------------------------------------------
module clss_check (
  input logic        clk,
  input logic        rst,
  input logic        site_valid,
  input logic        site_ready,
  input logic        parent_valid,
  input logic        parent_ready,
  input logic [15:0] c_log0,
  input logic [15:0] c_log1,
  input logic [15:0] c_log2,
  input logic [15:0] c_log3,
  input logic        underflow
);
  import clss_pkg::*;

  logic [7:0] pending;
  logic       site_xfer;
  logic       parent_xfer;

  assign site_xfer   = site_valid && site_ready;
  assign parent_xfer = parent_valid && parent_ready;

  // sites taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (site_xfer && !parent_xfer) begin
      pending <= pending + 1'b1;
    end else if (parent_xfer && !site_xfer) begin
      pending <= pending - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    parent_valid && !parent_ready |=> parent_valid && $stable(c_log0) &&
    $stable(c_log1) && $stable(c_log2) && $stable(c_log3))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    parent_valid |-> pending != 8'd0)
    else $error("result without an outstanding site");

  a_uf_code: assert property (@(posedge clk) disable iff (rst)
    parent_valid && underflow |-> (c_log0 == ZERO_CODE) || (c_log1 == ZERO_CODE) ||
    (c_log2 == ZERO_CODE) || (c_log3 == ZERO_CODE))
    else $error("underflow flag without zero code");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !parent_valid)
    else $error("result valid right after reset");

endmodule

bind conditional_likelihood_site_step clss_check u_check (
  .clk          (clk),
  .rst          (rst),
  .site_valid   (site.valid),
  .site_ready   (site.ready),
  .parent_valid (parent.valid),
  .parent_ready (parent.ready),
  .c_log0       (parent.c_log0),
  .c_log1       (parent.c_log1),
  .c_log2       (parent.c_log2),
  .c_log3       (parent.c_log3),
  .underflow    (parent.underflow)
);
